// ===== rtl/core/box_filter_downscale_top_assert.svh =====
// ----------------------------------------------------------------------------
// Box filter downscaler assertion macros
// Checks run on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_DOWNSCALE_TOP_ASSERT_SVH
`define BOX_FILTER_DOWNSCALE_TOP_ASSERT_SVH

// Condition must never hold at a clock edge.
`define BFDS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define BFDS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bfds_pkg.sv =====
// ----------------------------------------------------------------------------
// bfds_pkg
// Shared types and constants of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfds_pkg;

  localparam int PIXEL_W        = 32;
  localparam int CHAN_W         = 8;
  localparam int CHANNELS       = 4;
  localparam int QUOT_W         = 8;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 2;
  localparam int RATIO_FIELD_W  = 5;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_W          = 12;
  localparam int ROW_END_W      = HEIGHT_FIELD_W + 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_RATIO   = 2'd0,
    REG_SOURCE_WIDTH  = 2'd1,
    REG_SOURCE_HEIGHT = 2'd2
  } cfg_reg_t;

  // Per-request control: first pixel of a block, block complete, final block.
  typedef struct packed {
    logic first;
    logic emit;
    logic last;
  } op_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/box_filter_downscale_top.sv =====
// ----------------------------------------------------------------------------
// Box filter image downscaler: a block's result travels from its bottom-right
// pixel through the column-sum memory read and the eight-stage divide
// pipeline to the output; throughput one pixel per cycle while results are
// popped. Synchronous reset clears counters and queues.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_filter_downscale_top_assert.svh"

module box_filter_downscale_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RATIO = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Source pixel queue side
  input  logic                                 push,
  input  logic [bfds_pkg::PIXEL_W-1:0]         in_pixel,
  output logic                                 full,
  // Result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bfds_pkg::PIXEL_W-1:0]         out_pixel,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_column,
  output logic [bfds_pkg::ROW_W-1:0]           out_row,
  output logic                                 last_of_image,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [bfds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bfds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RW        = $clog2(MAX_RATIO + 1);
  localparam int SQ_W      = 2 * RW;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int HW        = bfds_pkg::HEIGHT_FIELD_W;
  localparam int FLAGS_W   = $bits(bfds_pkg::op_flags_t);
  localparam int OP_W      = bfds_pkg::PIXEL_W + CW + bfds_pkg::ROW_W + FLAGS_W;
  localparam int RES_W     = bfds_pkg::PIXEL_W + CW + bfds_pkg::ROW_W + 1;
  localparam int OP_DEPTH  = 4;
  // Deep enough to cover the divide pipeline and keep one pixel per cycle.
  localparam int RES_DEPTH = 16;
  localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // --------------------------------------------------------------------------
  // Configuration registers, kept already clamped to their legal ranges.
  // --------------------------------------------------------------------------
  logic [RW-1:0]   ratio;
  logic [SQ_W-1:0] ratio_sq;
  logic [WW-1:0]   width;
  logic [HW-1:0]   height;

  logic [bfds_pkg::RATIO_FIELD_W-1:0] ratio_field;
  logic [bfds_pkg::WIDTH_FIELD_W-1:0] width_field;
  logic [HW-1:0]                      height_field;
  logic [RW-1:0]                      ratio_clamped;
  logic [WW-1:0]                      width_clamped;
  logic [HW-1:0]                      height_clamped;
  logic [RW-1:0]                      ratio_next;

  assign ratio_field  = cfg_data[bfds_pkg::RATIO_FIELD_W-1:0];
  assign width_field  = cfg_data[bfds_pkg::WIDTH_FIELD_W-1:0];
  assign height_field = cfg_data[HW-1:0];

  // Zero means one; anything above the maximum saturates.
  assign ratio_clamped = (ratio_field == '0) ? RW'(1) :
                         (32'(ratio_field) > MAX_RATIO) ? RW'(MAX_RATIO) :
                         RW'(ratio_field);
  assign width_clamped = (width_field == '0) ? WW'(1) :
                         (32'(width_field) > MAX_WIDTH) ? WW'(MAX_WIDTH) :
                         WW'(width_field);
  assign height_clamped = (height_field == '0) ? HW'(1) :
                          (32'(height_field) > bfds_pkg::MAX_HEIGHT) ?
                          HW'(bfds_pkg::MAX_HEIGHT) : height_field;

  // Ratio that holds once this cycle's write lands; the front restarts with it.
  assign ratio_next = (cfg_we && (cfg_index == bfds_pkg::REG_BLOCK_RATIO)) ?
                      ratio_clamped : ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio    <= RW'(1);
      ratio_sq <= SQ_W'(1);
      width    <= WW'(WIDTH_RESET);
      height   <= HW'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        bfds_pkg::REG_BLOCK_RATIO: begin
          ratio    <= ratio_clamped;
          ratio_sq <= SQ_W'(ratio_clamped) * SQ_W'(ratio_clamped);
        end
        bfds_pkg::REG_SOURCE_WIDTH: begin
          width <= width_clamped;
        end
        bfds_pkg::REG_SOURCE_HEIGHT: begin
          height <= height_clamped;
        end
        default: begin
          // Unlisted index: register file unchanged, frame still restarts.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front: track the raster position and classify each accepted pixel.
  // Pixels outside every whole block are dropped here.
  // --------------------------------------------------------------------------
  logic                       in_take;
  logic                       op_valid;
  logic [CW-1:0]              op_column;
  logic [bfds_pkg::ROW_W-1:0] op_row;
  bfds_pkg::op_flags_t        op_flags;

  assign in_take = push && !full;

  bfds_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RATIO (MAX_RATIO)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .ratio_restart (ratio_next),
    .ratio         (ratio),
    .width         (width),
    .height        (height),
    .push          (in_take),
    .op_valid      (op_valid),
    .op_column     (op_column),
    .op_row        (op_row),
    .op_flags      (op_flags)
  );

  // --------------------------------------------------------------------------
  // Request queue between front and back; its full flag is the input full.
  // --------------------------------------------------------------------------
  logic [OP_W-1:0]             op_wdata;
  logic [OP_W-1:0]             op_rdata;
  logic                        op_full;
  logic                        op_empty;
  logic                        op_pop;
  logic [bfds_pkg::PIXEL_W-1:0] q_pixel;
  logic [CW-1:0]               q_column;
  logic [bfds_pkg::ROW_W-1:0]  q_row;
  bfds_pkg::op_flags_t         q_flags;

  assign op_wdata = {in_pixel, op_column, op_row, op_flags};
  assign {q_pixel, q_column, q_row, q_flags} = op_rdata;
  assign full = op_full;

  bfds_queue #(
    .WIDTH (OP_W),
    .DEPTH (OP_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid),
    .wdata (op_wdata),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_rdata),
    .empty (op_empty)
  );

  // --------------------------------------------------------------------------
  // Back: accumulate into the column sums and divide completed blocks.
  // It reserves a result slot before taking a completing request, so the
  // result queue never overflows and the pipeline never stalls inside.
  // --------------------------------------------------------------------------
  logic                        res_push;
  logic                        res_take;
  logic [bfds_pkg::PIXEL_W-1:0] res_pixel;
  logic [CW-1:0]               res_column;
  logic [bfds_pkg::ROW_W-1:0]  res_row;
  logic                        res_last;

  assign res_take = pop && !empty;

  bfds_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RATIO (MAX_RATIO),
    .OUT_DEPTH (RES_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_empty   (op_empty),
    .op_pixel   (q_pixel),
    .op_column  (q_column),
    .op_row     (q_row),
    .op_flags   (q_flags),
    .ratio_sq   (ratio_sq),
    .res_pop    (res_take),
    .op_pop     (op_pop),
    .res_push   (res_push),
    .res_pixel  (res_pixel),
    .res_column (res_column),
    .res_row    (res_row),
    .res_last   (res_last)
  );

  // --------------------------------------------------------------------------
  // Result queue: the oldest averaged pixel sits on the output ports.
  // --------------------------------------------------------------------------
  logic [RES_W-1:0] res_wdata;
  logic [RES_W-1:0] res_rdata;
  logic             res_full;

  assign res_wdata = {res_pixel, res_column, res_row, res_last};
  assign {out_pixel, out_column, out_row, last_of_image} = res_rdata;

  bfds_queue #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BFDS_NEVER(a_res_no_overflow, res_push && res_full, "result queue overflow")
  `BFDS_NEVER(a_op_pop_nonempty, op_pop && op_empty, "request popped from empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/bfds_queue.sv =====
// ----------------------------------------------------------------------------
// bfds_queue
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bfds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfds_front.sv =====
// ----------------------------------------------------------------------------
// bfds_front
// Raster position tracking; classifies each source pixel against its block.
// ----------------------------------------------------------------------------
`default_nettype none

module bfds_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RATIO = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  restart,
  input  logic [$clog2(MAX_RATIO+1)-1:0]        ratio_restart,
  input  logic [$clog2(MAX_RATIO+1)-1:0]        ratio,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width,
  input  logic [bfds_pkg::HEIGHT_FIELD_W-1:0]   height,
  input  logic                                  push,
  output logic                                  op_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]          op_column,
  output logic [bfds_pkg::ROW_W-1:0]            op_row,
  output bfds_pkg::op_flags_t                   op_flags
);

  localparam int RW  = $clog2(MAX_RATIO + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int IW  = $clog2(MAX_RATIO);
  localparam int EW  = WW + 1;
  localparam int REW = bfds_pkg::ROW_END_W;

  logic [CW-1:0]                  source_column;
  logic [bfds_pkg::ROW_W-1:0]     source_row;
  logic [IW-1:0]                  column_in_block;
  logic [IW-1:0]                  row_in_block;
  logic [CW-1:0]                  block_column;
  logic [bfds_pkg::ROW_W-1:0]     block_row;
  logic [EW-1:0]                  block_end;
  logic [REW-1:0]                 row_end;

  logic col_fits;
  logic row_fits;
  logic cib_last;
  logic rib_last;
  logic col_wrap;
  logic row_wrap;

  // Block end is the source column just right of the current block.
  assign col_fits = (block_end <= EW'(width));
  assign row_fits = (row_end <= REW'(height));
  assign cib_last = (column_in_block == IW'(ratio - RW'(1)));
  assign rib_last = (row_in_block == IW'(ratio - RW'(1)));
  assign col_wrap = (source_column == CW'(width - WW'(1)));
  assign row_wrap = (source_row == bfds_pkg::ROW_W'(height - bfds_pkg::HEIGHT_FIELD_W'(1)));

  assign op_valid       = push && col_fits && row_fits;
  assign op_column      = block_column;
  assign op_row         = block_row;
  assign op_flags.first = (row_in_block == '0) && (column_in_block == '0);
  assign op_flags.emit  = cib_last && rib_last;
  assign op_flags.last  = (block_end + EW'(ratio) > EW'(width)) &&
                          (row_end + REW'(ratio) > REW'(height));

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column   <= '0;
      source_row      <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      block_column    <= '0;
      block_row       <= '0;
      block_end       <= EW'(1);
      row_end         <= REW'(1);
    end else if (restart) begin
      source_column   <= '0;
      source_row      <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      block_column    <= '0;
      block_row       <= '0;
      block_end       <= EW'(ratio_restart);
      row_end         <= REW'(ratio_restart);
    end else if (push) begin
      if (col_wrap) begin
        source_column   <= '0;
        column_in_block <= '0;
        block_column    <= '0;
        block_end       <= EW'(ratio);
        if (row_wrap) begin
          source_row   <= '0;
          row_in_block <= '0;
          block_row    <= '0;
          row_end      <= REW'(ratio);
        end else begin
          source_row <= source_row + bfds_pkg::ROW_W'(1);
          if (rib_last) begin
            row_in_block <= '0;
            block_row    <= block_row + bfds_pkg::ROW_W'(1);
            row_end      <= row_end + REW'(ratio);
          end else begin
            row_in_block <= row_in_block + IW'(1);
          end
        end
      end else begin
        source_column <= source_column + CW'(1);
        if (cib_last) begin
          column_in_block <= '0;
          block_column    <= block_column + CW'(1);
          block_end       <= block_end + EW'(ratio);
        end else begin
          column_in_block <= column_in_block + IW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfds_back.sv =====
// ----------------------------------------------------------------------------
// bfds_back
// Column sum read-modify-write and pipelined averaging divide.
// ----------------------------------------------------------------------------
`default_nettype none

module bfds_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RATIO = 16,
  parameter int OUT_DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    op_empty,
  input  logic [bfds_pkg::PIXEL_W-1:0]            op_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0]            op_column,
  input  logic [bfds_pkg::ROW_W-1:0]              op_row,
  input  bfds_pkg::op_flags_t                     op_flags,
  input  logic [2*$clog2(MAX_RATIO+1)-1:0]        ratio_sq,
  input  logic                                    res_pop,
  output logic                                    op_pop,
  output logic                                    res_push,
  output logic [bfds_pkg::PIXEL_W-1:0]            res_pixel,
  output logic [$clog2(MAX_WIDTH)-1:0]            res_column,
  output logic [bfds_pkg::ROW_W-1:0]              res_row,
  output logic                                    res_last
);

  localparam int RW     = $clog2(MAX_RATIO + 1);
  localparam int SQ_W   = 2 * RW;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CH     = bfds_pkg::CHANNELS;
  localparam int CHW    = bfds_pkg::CHAN_W;
  localparam int SUM_W  = CHW + 2 * $clog2(MAX_RATIO);
  localparam int MEM_W  = SUM_W * CH;
  localparam int QW     = bfds_pkg::QUOT_W;
  localparam int CMP_W  = SQ_W + QW;
  localparam int NSTEP  = QW;
  localparam int CRW    = $clog2(OUT_DEPTH + 1);

  // Result slots reserved: in flight plus waiting in the result queue.
  logic [CRW-1:0]              used;
  logic [CRW-1:0]              used_next;

  logic [MEM_W-1:0]            sums [MAX_WIDTH];
  logic [MEM_W-1:0]            rd_word;

  logic                        s1_valid;
  logic [bfds_pkg::PIXEL_W-1:0] s1_pixel;
  logic [CW-1:0]               s1_column;
  logic [bfds_pkg::ROW_W-1:0]  s1_row;
  bfds_pkg::op_flags_t         s1_flags;

  logic                        fwd_valid;
  logic [CW-1:0]               fwd_column;
  logic [MEM_W-1:0]            fwd_word;
  logic [MEM_W-1:0]            base_word;
  logic [MEM_W-1:0]            new_word;

  logic                        dv_valid  [NSTEP];
  logic [SUM_W-1:0]            dv_rem    [NSTEP][CH];
  logic [QW-1:0]               dv_quot   [NSTEP][CH];
  logic [CW-1:0]               dv_column [NSTEP];
  logic [bfds_pkg::ROW_W-1:0]  dv_row    [NSTEP];
  logic                        dv_last   [NSTEP];
  logic [CMP_W-1:0]            trial     [NSTEP];
  logic [SUM_W-1:0]            st_rem    [NSTEP][CH];
  logic [QW-1:0]               st_quot   [NSTEP][CH];

  // Hold a completing request until a result slot is free.
  assign op_pop = !op_empty && (!op_flags.emit || (used < CRW'(OUT_DEPTH)));

  always_comb begin
    used_next = used;
    if (op_pop && op_flags.emit) begin
      used_next = used_next + CRW'(1);
    end
    if (res_pop) begin
      used_next = used_next - CRW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      used      <= used_next;
      s1_valid  <= op_pop;
      fwd_valid <= s1_valid;
    end
  end

  // Column sum memory: one write and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      sums[s1_column] <= new_word;
    end
    rd_word <= sums[op_column];
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s1_pixel  <= op_pixel;
      s1_column <= op_column;
      s1_row    <= op_row;
      s1_flags  <= op_flags;
    end
    fwd_column <= s1_column;
    fwd_word   <= new_word;
  end

  // Bypass the write of the previous cycle, which the read missed.
  assign base_word = (fwd_valid && (fwd_column == s1_column)) ? fwd_word : rd_word;

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      if (s1_flags.first) begin
        new_word[i*SUM_W +: SUM_W] = SUM_W'(s1_pixel[i*CHW +: CHW]);
      end else begin
        new_word[i*SUM_W +: SUM_W] = base_word[i*SUM_W +: SUM_W] +
                                     SUM_W'(s1_pixel[i*CHW +: CHW]);
      end
    end
  end

  // One restoring quotient bit per stage; the quotient fits in one channel.
  always_comb begin
    for (int k = 0; k < NSTEP; k++) begin
      trial[k] = CMP_W'(ratio_sq) << (QW - 1 - k);
      for (int i = 0; i < CH; i++) begin
        st_rem[k][i]  = dv_rem[k][i];
        st_quot[k][i] = dv_quot[k][i];
        if (CMP_W'(dv_rem[k][i]) >= trial[k]) begin
          st_rem[k][i]             = SUM_W'(CMP_W'(dv_rem[k][i]) - trial[k]);
          st_quot[k][i][QW-1-k]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTEP; k++) begin
        dv_valid[k] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= s1_valid && s1_flags.emit;
      for (int k = 0; k < NSTEP - 1; k++) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CH; i++) begin
      dv_rem[0][i]  <= new_word[i*SUM_W +: SUM_W];
      dv_quot[0][i] <= '0;
    end
    dv_column[0] <= s1_column;
    dv_row[0]    <= s1_row;
    dv_last[0]   <= s1_flags.last;
    for (int k = 0; k < NSTEP - 1; k++) begin
      for (int i = 0; i < CH; i++) begin
        dv_rem[k+1][i]  <= st_rem[k][i];
        dv_quot[k+1][i] <= st_quot[k][i];
      end
      dv_column[k+1] <= dv_column[k];
      dv_row[k+1]    <= dv_row[k];
      dv_last[k+1]   <= dv_last[k];
    end
  end

  assign res_push   = dv_valid[NSTEP-1];
  assign res_column = dv_column[NSTEP-1];
  assign res_row    = dv_row[NSTEP-1];
  assign res_last   = dv_last[NSTEP-1];

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      res_pixel[i*CHW +: CHW] = st_quot[NSTEP-1][i];
    end
  end

endmodule

`default_nettype wire
